FILE: rtl/core/blm_pkg.sv
// blm_pkg: shared types, widths and helpers for the busy load monitor
// no dependencies; imported by busy_load_monitor and tb_busy_load_monitor
package blm_pkg;

  // number of tracked key slots and their index width
  localparam int unsigned NumSlots  = 4;
  localparam int unsigned SlotW     = 3;
  localparam logic [SlotW-1:0] SlotNone = 3'd4;

  // configuration port
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  // field widths
  localparam int unsigned KeyW      = 32;
  localparam int unsigned AvgW      = 24;
  localparam int unsigned PctW      = 7;
  localparam int unsigned StreakW   = 8;
  localparam int unsigned WinLen    = 16;
  localparam int unsigned WinCntW   = 5;
  localparam int unsigned CountW    = 32;

  // stream widths, padded to whole bytes
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 136;

  localparam logic [StreakW-1:0] StreakMax = 8'd255;
  localparam logic [6:0]         PctScale  = 7'd100;

  // result beat, first field in the highest bits
  typedef struct packed {
    logic [KeyW-1:0]    pending_key;
    logic [CountW-1:0]  hit_count;
    logic [SlotW-1:0]   hit_slot;
    logic [CountW-1:0]  samples_seen;
    logic [WinCntW-1:0] window_peak;
    logic [WinCntW-1:0] window_count;
    logic [StreakW-1:0] max_streak;
    logic [StreakW-1:0] streak;
    logic [PctW-1:0]    load_percent;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  // population count of the busy window
  function automatic logic [WinCntW-1:0] ones16(input logic [WinLen-1:0] v);
    logic [WinCntW-1:0] n;
    n = '0;
    for (int i = 0; i < WinLen; i++) begin
      n = n + WinCntW'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/busy_load_monitor.sv
// busy_load_monitor: tick-sample load monitor with moving average, streaks,
// busy window statistics and four-slot key hit counting
// an accepted input beat passes the input register, then the result register
// throughput: one beat per cycle while the output is not stalled; the input
// register feeds one update stage whose state and result register load together
// reset: rst_ni asynchronous active low clears all statistics, key slots,
// the pending key and both valid flags; no clearing pass is needed
module busy_load_monitor
  import blm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: busy_req [0], sample_key [32:1], zero pad [39:33]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: load_percent [6:0], streak [14:7], max_streak [22:15],
  // window_count [27:23], window_peak [32:28], samples_seen [64:33],
  // hit_slot [67:65], hit_count [99:68], pending_key [131:100], zero pad [135:132]
  output logic [OutDataW-1:0] m_axis_tdata
);

  // key slot registers
  logic [KeyW-1:0] key_slot_q [NumSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) key_slot_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumSlots))) begin
      key_slot_q[cfg_idx_i[1:0]] <= cfg_data_i;
    end
  end

  // pipeline handshake
  logic in_valid_q, out_valid_q;
  logic advance;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;

  // input register
  logic            busy_q;
  logic [KeyW-1:0] key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      busy_q <= s_axis_tdata[0];
      key_q  <= s_axis_tdata[KeyW:1];
    end
  end

  // statistics state
  logic [AvgW-1:0]    avg_q, avg_d;
  logic [CountW-1:0]  samples_q, samples_d;
  logic [StreakW-1:0] streak_q, streak_d;
  logic [StreakW-1:0] longest_q, longest_d;
  logic [WinLen-1:0]  window_q, window_d;
  logic [WinCntW-1:0] peak_q, peak_d;
  logic [CountW-1:0]  slot_cnt_q [NumSlots];
  logic [KeyW-1:0]    captured_q, captured_d;

  // exponential average: avg*255 + busy<<24, then >>8
  logic [AvgW+8:0]  avg_acc;
  logic [AvgW+6:0]  pct_prod;
  logic [WinCntW-1:0] win_cnt;
  logic [SlotW-1:0]   hit;
  logic [CountW-1:0]  hit_cnt;
  result_t            res_d, res_q;

  always_comb begin
    avg_acc = ({1'b0, avg_q, 8'd0} - (AvgW+9)'(avg_q))
            + ((AvgW+9)'(busy_q) << AvgW);
    avg_d   = avg_acc[AvgW+7:8];
    pct_prod = (AvgW+7)'(avg_d) * (AvgW+7)'(PctScale);
  end

  // streak, window and sample counter
  always_comb begin
    samples_d = samples_q + 1'b1;
    streak_d  = streak_q;
    longest_d = longest_q;
    if (busy_q) begin
      if (streak_q < StreakMax) streak_d = streak_q + 1'b1;
      if (streak_d > longest_q) longest_d = streak_d;
    end else begin
      streak_d = '0;
    end
    window_d = {window_q[WinLen-2:0], busy_q};
    win_cnt  = ones16(window_d);
    peak_d   = (win_cnt > peak_q) ? win_cnt : peak_q;
  end

  // key compare, lowest matching slot wins
  always_comb begin
    hit = SlotNone;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (key_q != '0 && key_slot_q[i] == key_q) hit = SlotW'(i);
    end
    hit_cnt    = '0;
    captured_d = captured_q;
    if (hit != SlotNone) begin
      hit_cnt = slot_cnt_q[hit[1:0]] + 1'b1;
    end else if (key_q != '0 && captured_q == '0) begin
      captured_d = key_q;
    end
  end

  // result fields
  always_comb begin
    res_d.load_percent = pct_prod[AvgW+PctW-1:AvgW];
    res_d.streak       = streak_d;
    res_d.max_streak   = longest_d;
    res_d.window_count = win_cnt;
    res_d.window_peak  = peak_d;
    res_d.samples_seen = samples_d;
    res_d.hit_slot     = hit;
    res_d.hit_count    = hit_cnt;
    res_d.pending_key  = captured_d;
  end

  // state update and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      samples_q   <= '0;
      streak_q    <= '0;
      longest_q   <= '0;
      window_q    <= '0;
      peak_q      <= '0;
      captured_q  <= '0;
      for (int i = 0; i < NumSlots; i++) slot_cnt_q[i] <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        avg_q       <= avg_d;
        samples_q   <= samples_d;
        streak_q    <= streak_d;
        longest_q   <= longest_d;
        window_q    <= window_d;
        peak_q      <= peak_d;
        captured_q  <= captured_d;
        if (hit != SlotNone) slot_cnt_q[hit[1:0]] <= hit_cnt;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign m_axis_tdata = {(OutDataW-ResultW)'(0), res_q};

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_q.streak <= res_q.max_streak)
    else $error("streak above its maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_q.window_count <= res_q.window_peak)
    else $error("window count above its peak");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.hit_slot == SlotNone) |-> res_q.hit_count == '0)
    else $error("hit count without a matching slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> ($stable(avg_q) && $stable(samples_q)))
    else $error("state changed while the update stage was stalled");

endmodule

FILE: dv/tb_busy_load_monitor.sv
// tb_busy_load_monitor: self-checking testbench for the busy load monitor
// a scoreboard class predicts every result beat from the accepted samples
// depends on blm_pkg and busy_load_monitor
`timescale 1ns / 100ps

module tb_busy_load_monitor;
  import blm_pkg::*;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] IdxSlotZero    = 3'd0;
  localparam logic [CfgIdxW-1:0] IdxSlotOne     = 3'd1;
  localparam logic [CfgIdxW-1:0] IdxSlotTwo     = 3'd2;
  localparam logic [CfgIdxW-1:0] IdxSlotThree   = 3'd3;
  localparam logic [CfgIdxW-1:0] IdxFirstUnused = 3'd4;
  localparam logic [CfgIdxW-1:0] IdxLastUnused  = 3'd7;

  localparam int unsigned ResetCycles = 12;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongBusyRun = 1200;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata: busy_req, sample_key, zero pad
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata: load_percent, streak, max_streak, window_count, window_peak,
  // samples_seen, hit_slot, hit_count, pending_key, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned src_idle_pct  = 17;
  int unsigned sink_idle_pct = 59;
  int unsigned cycles        = 0;

  // predicts load statistics and key hits, holds the reports still due
  class load_scoreboard;
    logic [KeyW-1:0]    key_slot[NumSlots];
    logic [CountW-1:0]  slot_cnt[NumSlots];
    logic [AvgW-1:0]    avg;
    logic [CountW-1:0]  sample_cnt;
    logic [StreakW-1:0] streak;
    logic [StreakW-1:0] longest;
    logic [WinLen-1:0]  window;
    logic [WinCntW-1:0] peak;
    logic [KeyW-1:0]    captured;
    result_t            reports_due[$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < NumSlots; i++) begin
        key_slot[i] = '0;
        slot_cnt[i] = '0;
      end
      avg        = '0;
      sample_cnt = '0;
      streak     = '0;
      longest    = '0;
      window     = '0;
      peak       = '0;
      captured   = '0;
      errors     = 0;
    endfunction

    // writes beyond the slot list are dropped
    function void set_key(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      if (idx < NumSlots) begin
        key_slot[idx[1:0]] = value;
      end
    endfunction

    function void note_sample(logic busy, logic [KeyW-1:0] key);
      logic [39:0]      acc;
      logic [31:0]      pct_prod;
      logic [SlotW-1:0] hit;
      result_t          r;
      // exponential average, busy weighs in as one in 24-bit fixed point
      acc = 40'(avg) * 40'd255;
      if (busy) begin
        acc = acc + (40'd1 << AvgW);
      end
      avg = AvgW'(acc >> 8);
      sample_cnt = sample_cnt + 1;
      // saturating busy streak and its maximum
      if (busy) begin
        if (streak != StreakMax) begin
          streak = streak + 1'b1;
        end
        if (streak > longest) begin
          longest = streak;
        end
      end else begin
        streak = '0;
      end
      // sixteen-sample window
      window = {window[WinLen-2:0], busy};
      r.window_count = WinCntW'($countones(window));
      if (r.window_count > peak) begin
        peak = r.window_count;
      end
      // key compare, lowest matching slot wins
      hit = SlotNone;
      r.hit_count = '0;
      if (key != '0) begin
        for (int i = NumSlots - 1; i >= 0; i--) begin
          if (key_slot[i] == key) begin
            hit = SlotW'(i);
          end
        end
        if (hit != SlotNone) begin
          slot_cnt[hit[1:0]] = slot_cnt[hit[1:0]] + 1;
          r.hit_count = slot_cnt[hit[1:0]];
        end else if (captured == '0) begin
          captured = key;
        end
      end
      pct_prod = 32'(avg) * 32'(PctScale);
      r.load_percent = PctW'(pct_prod >> AvgW);
      r.streak       = streak;
      r.max_streak   = longest;
      r.window_peak  = peak;
      r.samples_seen = sample_cnt;
      r.hit_slot     = hit;
      r.pending_key  = captured;
      reports_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (reports_due.size() == 0) begin
        $display("%0t: result beat with none expected, actual %0h", $time, got);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      compare_field("load_percent", 32'(want.load_percent), 32'(got.load_percent));
      compare_field("streak", 32'(want.streak), 32'(got.streak));
      compare_field("max_streak", 32'(want.max_streak), 32'(got.max_streak));
      compare_field("window_count", 32'(want.window_count), 32'(got.window_count));
      compare_field("window_peak", 32'(want.window_peak), 32'(got.window_peak));
      compare_field("samples_seen", want.samples_seen, got.samples_seen);
      compare_field("hit_slot", 32'(want.hit_slot), 32'(got.hit_slot));
      compare_field("hit_count", want.hit_count, got.hit_count);
      compare_field("pending_key", want.pending_key, got.pending_key);
    endfunction
  endclass

  load_scoreboard board;

  busy_load_monitor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // watch both streams; a sample is noted before any result of the same edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      board.note_sample(s_axis_tdata[0], s_axis_tdata[KeyW:1]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_report(result_t'(m_axis_tdata[ResultW-1:0]));
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(input logic busy, input logic [KeyW-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {(InDataW - KeyW - 1)'(0), key, busy};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  // hold off until every result has come, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all four slots, then one write to an index past the list
  task automatic load_key_slots(input logic [KeyW-1:0] k0, input logic [KeyW-1:0] k1,
                                input logic [KeyW-1:0] k2, input logic [KeyW-1:0] k3);
    logic [KeyW-1:0]    keys[NumSlots];
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] junk;
    keys[IdxSlotZero[1:0]]  = k0;
    keys[IdxSlotOne[1:0]]   = k1;
    keys[IdxSlotTwo[1:0]]   = k2;
    keys[IdxSlotThree[1:0]] = k3;
    for (int i = 0; i < NumSlots; i++) begin
      idx = CfgIdxW'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= keys[i];
      board.set_key(idx, keys[i]);
      @(posedge clk_i);
    end
    idx  = CfgIdxW'($urandom_range(IdxLastUnused, IdxFirstUnused));
    junk = $urandom;
    cfg_idx_i  <= idx;
    cfg_data_i <= junk;
    board.set_key(idx, junk);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // slot keys most often, some zero, near misses, all ones and random keys
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 8) begin
      return board.key_slot[$urandom_range(NumSlots - 1)];
    end else if (sel < 11) begin
      return '0;
    end else if (sel < 13) begin
      return board.key_slot[$urandom_range(NumSlots - 1)] ^ (32'd1 << $urandom_range(31));
    end else if (sel == 13) begin
      return '1;
    end
    return $urandom;
  endfunction

  // alternating busy and quiet runs, now and then long enough to saturate
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    logic        busy;
    sent = 0;
    busy = 1'b0;
    while (sent < n_items) begin
      busy = ~busy;
      run_len = ($urandom_range(19) == 0) ? $urandom_range(300, 200) : $urandom_range(20, 1);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        send_sample(($urandom_range(9) == 0) ? 1'($urandom) : busy, pick_key());
        sent++;
      end
    end
  endtask

  initial begin
    logic [KeyW-1:0] dup_key;
    board = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme keys, duplicate slot keys, capture and held capture
    src_idle_pct  = 17;
    sink_idle_pct = 59;
    load_key_slots(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
    send_sample(1'b0, 32'h0);
    send_sample(1'b1, 32'h0);
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0001);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b1, 32'h1234_5678);
    send_sample(1'b1, 32'hFFFF_FFFE);
    // full busy window
    for (int k = 0; k < WinLen; k++) begin
      send_sample(1'b1, board.key_slot[k % NumSlots]);
    end
    drain_results();

    // phase one: empty slot two, long busy run drives the load near full
    load_key_slots($urandom, $urandom, 32'h0, $urandom);
    for (int k = 0; k < LongBusyRun; k++) begin
      send_sample(1'b1, pick_key());
    end
    run_random(150);
    drain_results();

    // phase two: roles of idling swapped, duplicate key in slots zero and two
    src_idle_pct  = 59;
    sink_idle_pct = 17;
    dup_key = $urandom;
    load_key_slots(dup_key, $urandom, dup_key, $urandom);
    run_random(150);
    drain_results();
    run_random(150);
    drain_results();

    // phase three: no idling, extreme slot values
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_key_slots(32'h0, 32'hFFFF_FFFF, $urandom, 32'h0000_0001);
    run_random(200);
    drain_results();

    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
